### sv/ddsdf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dual-channel DDS DAC feeder.
// No dependencies; the interfaces, top level, checker and bench import this package.
package ddsdf_pkg;

  localparam int OPC_W      = 3;
  localparam int IDX_W      = 12;
  localparam int CODE_W     = 12;
  localparam int BURST_W    = 16;
  localparam int WORD_W     = 16;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPC_W-1:0] OPC_TICK  = 3'd0;
  localparam logic [OPC_W-1:0] OPC_WRITE = 3'd1;
  localparam logic [OPC_W-1:0] OPC_RUN   = 3'd2;
  localparam logic [OPC_W-1:0] OPC_STOP  = 3'd3;
  localparam logic [OPC_W-1:0] OPC_BURST = 3'd4;
  localparam logic [OPC_W-1:0] OPC_DC    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B = 1'b1;

  localparam logic CHAN_A = 1'b0;
  localparam logic CHAN_B = 1'b1;

  // DAC command bits for channel A and channel B frames
  localparam logic [WORD_W-1:0] CMD_A = 16'h3000;
  localparam logic [WORD_W-1:0] CMD_B = 16'hB000;

  typedef enum logic [2:0] {
    MODE_RUN  = 3'b001,
    MODE_DC   = 3'b010,
    MODE_STOP = 3'b100
  } run_mode_t;

endpackage

### sv/ddsdf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command input and DAC frame output.
// Depends on ddsdf_pkg for field widths.
interface ddsdf_in_if;
  import ddsdf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPC_W-1:0]     opcode;
  logic                 channel;
  logic [IDX_W-1:0]     table_index;
  logic [CODE_W-1:0]    sample_code;
  logic [BURST_W-1:0]   burst_count;

  modport source (output valid, opcode, channel, table_index, sample_code, burst_count,
                  input ready);
  modport sink   (input valid, opcode, channel, table_index, sample_code, burst_count,
                  output ready);
endinterface

interface ddsdf_out_if;
  import ddsdf_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   dac_word;
  logic                last;

  modport source (output valid, dac_word, last, input ready);
  modport sink   (input valid, dac_word, last, output ready);
endinterface

### sv/ddsdf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ddsdf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/dual_channel_dds_dac_feeder_top.sv
`timescale 1ns / 1ps
//  channel | dir | handshake     | payload
//  in_if   | in  | valid / ready | opcode, channel, table_index, sample_code, burst_count
//  out_if  | out | valid / ready | dac_word, last
//  cfg_*   | in  | cfg_we        | cfg_index, cfg_data (phase steps A and B)
// A run-mode tick yields two frames, an A frame then a B frame, on the single output port;
// the next tick can wait in the frame stage while those drain. RAM table reads are
// registered. Other transactions are taken at one per cycle unless the output stalls.
// Reset is synchronous: accumulators, steps, burst count clear and the block stops;
// table contents are not cleared. A stalled output holds one frame plus one queued frame.
module dual_channel_dds_dac_feeder_top #(
  parameter int TABLE_DEPTH = 4096,  // power of two
  parameter int INDEX_SHIFT = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ddsdf_in_if.sink                             in_if,
  ddsdf_out_if.source                          out_if,
  input  logic                                 cfg_we,
  input  logic [ddsdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddsdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ddsdf_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // architectural state
  logic [ACC_W-1:0]   step_a_r, step_b_r;
  logic [ACC_W-1:0]   acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  run_mode_t          mode_r, mode_nxt;
  logic [BURST_W-1:0] ticks_r, ticks_nxt;

  // pipeline
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_dc_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [WORD_W-1:0] pend_word_r, pend_word_nxt;

  logic              in_fire, run_tick, dc_wr, s1_move;
  logic              we_a, we_b;
  logic [ACC_W-1:0]  acc_a_sum, acc_b_sum, sh_a, sh_b, idx_ext;
  logic [AW-1:0]     raddr_a, raddr_b, waddr;
  logic [CODE_W-1:0] q_a, q_b;

  assign in_fire  = in_if.valid && in_if.ready;
  assign run_tick = in_fire && (in_if.opcode == OPC_TICK) && (mode_r == MODE_RUN);
  assign dc_wr    = in_fire && (in_if.opcode == OPC_DC);
  assign s1_move  = s1_valid_r && !pend_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_move;

  assign acc_a_sum = acc_a_r + step_a_r;
  assign acc_b_sum = acc_b_r + step_b_r;
  assign sh_a      = acc_a_sum >> INDEX_SHIFT;
  assign sh_b      = acc_b_sum >> INDEX_SHIFT;
  assign raddr_a   = sh_a[AW-1:0];
  assign raddr_b   = sh_b[AW-1:0];
  assign idx_ext   = {{(ACC_W-IDX_W){1'b0}}, in_if.table_index};
  assign waddr     = idx_ext[AW-1:0];

  assign we_a = in_fire && (in_if.opcode == OPC_WRITE) && (in_if.channel == CHAN_A);
  assign we_b = in_fire && (in_if.opcode == OPC_WRITE) && (in_if.channel == CHAN_B);

  ddsdf_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_tab_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(in_if.sample_code),
    .re(run_tick), .raddr(raddr_a), .rdata(q_a)
  );

  ddsdf_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_tab_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(in_if.sample_code),
    .re(run_tick), .raddr(raddr_b), .rdata(q_b)
  );

  // mode, burst and accumulator updates, all applied at acceptance
  always_comb begin
    mode_nxt  = mode_r;
    ticks_nxt = ticks_r;
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    if (in_fire) begin
      case (in_if.opcode)
        OPC_TICK: begin
          if (mode_r == MODE_RUN) begin
            acc_a_nxt = acc_a_sum;
            acc_b_nxt = acc_b_sum;
            if (ticks_r != '0) begin
              ticks_nxt = ticks_r - BURST_W'(1);
              // burst expires after this tick's frames
              if (ticks_r == BURST_W'(1)) begin
                mode_nxt = MODE_STOP;
              end
            end
          end
        end
        OPC_RUN:   mode_nxt  = MODE_RUN;
        OPC_STOP:  mode_nxt  = MODE_STOP;
        OPC_BURST: ticks_nxt = in_if.burst_count;
        OPC_DC:    mode_nxt  = MODE_DC;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (run_tick || dc_wr) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // output register plus one queued B frame
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_word_nxt  = pend_word_r;
    if (out_valid_r && out_if.ready) begin
      if (pend_valid_r) begin
        out_word_nxt   = pend_word_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      if (s1_dc_r) begin
        out_word_nxt = s1_word_r;
        out_last_nxt = 1'b1;
      end else begin
        out_word_nxt   = CMD_A | {{(WORD_W-CODE_W){1'b0}}, q_a};
        out_last_nxt   = 1'b0;
        pend_valid_nxt = 1'b1;
        pend_word_nxt  = CMD_B | {{(WORD_W-CODE_W){1'b0}}, q_b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_a_r     <= '0;
      step_b_r     <= '0;
      acc_a_r      <= '0;
      acc_b_r      <= '0;
      mode_r       <= MODE_STOP;
      ticks_r      <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_A: step_a_r <= cfg_data;
          REG_STEP_B: step_b_r <= cfg_data;
          default: ;
        endcase
      end
      acc_a_r      <= acc_a_nxt;
      acc_b_r      <= acc_b_nxt;
      mode_r       <= mode_nxt;
      ticks_r      <= ticks_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_tick || dc_wr) begin
      s1_dc_r   <= dc_wr;
      s1_word_r <= ((in_if.channel == CHAN_B) ? CMD_B : CMD_A)
                   | {{(WORD_W-CODE_W){1'b0}}, in_if.sample_code};
    end
    out_word_r  <= out_word_nxt;
    out_last_r  <= out_last_nxt;
    pend_word_r <= pend_word_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.dac_word = out_word_r;
  assign out_if.last     = out_last_r;

endmodule

### sv/ddsdf_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the DDS DAC feeder output channel, bound to the top level.
// Depends on ddsdf_pkg and dual_channel_dds_dac_feeder_top.
module ddsdf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ddsdf_pkg::WORD_W-1:0] out_dac_word,
  input logic                         out_last
);
  import ddsdf_pkg::*;

  // a stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_word) && $stable(out_last))
    else $error("output frame changed while stalled");

  // a frame that is not the last of its transaction is always a channel A frame
  a_a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_dac_word[15:12] == CMD_A[15:12])
    else $error("non-final frame is not a channel A frame");

  // the B frame of a tick follows its A frame in the very next cycle
  a_b_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last
      |=> out_valid && out_last && out_dac_word[15:12] == CMD_B[15:12])
    else $error("channel B frame did not follow channel A frame");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind dual_channel_dds_dac_feeder_top ddsdf_checker u_ddsdf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_dac_word (out_if.dac_word),
  .out_last     (out_if.last)
);

### tb/tb_dual_channel_dds_dac_feeder_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the dual-channel DDS DAC feeder: directed command table, then
// random phases, stalled on both channels except the last. Needs ddsdf_pkg, ddsdf_if and the top.
module tb_dual_channel_dds_dac_feeder_top;
  import ddsdf_pkg::*;

  localparam int TBL_DEPTH  = 4096;
  localparam int IDX_SHIFT  = 20;
  localparam int WDOG_LIMIT = 4000;
  localparam int PHASE_CMDS = 600;
  localparam logic [OPC_W-1:0] OPC_RSVD6 = 3'd6;
  localparam logic [OPC_W-1:0] OPC_RSVD7 = 3'd7;

  typedef struct {
    logic [OPC_W-1:0]   op;
    logic               chan;
    logic [IDX_W-1:0]   idx;
    logic [CODE_W-1:0]  code;
    logic [BURST_W-1:0] burst;
  } cmd_t;

  typedef struct {
    cmd_t              cmd;
    bit                typed;
    int                n;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } cmd_row_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } frame_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ddsdf_in_if  in_ch ();
  ddsdf_out_if out_ch ();

  dual_channel_dds_dac_feeder_top #(
    .TABLE_DEPTH(TBL_DEPTH),
    .INDEX_SHIFT(IDX_SHIFT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the synthesizer state
  logic [ACC_W-1:0]   step_a, step_b, acc_a, acc_b;
  logic [CODE_W-1:0]  tbl_a [TBL_DEPTH];
  logic [CODE_W-1:0]  tbl_b [TBL_DEPTH];
  bit                 wr_a [TBL_DEPTH];
  bit                 wr_b [TBL_DEPTH];
  run_mode_t          mode;
  logic [BURST_W-1:0] burst_left;

  frame_t   dac_frames_due[$];
  cmd_row_t dir_rows[$];

  int src_idle_pct, snk_idle_pct;
  int mismatches = 0;
  int frames_checked = 0;
  int run_ticks, dc_frames, tbl_writes, cmds_sent;
  int idle_cycles = 0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [IDX_W-1:0] tbl_addr(input logic [ACC_W-1:0] acc);
    return IDX_W'((acc >> IDX_SHIFT) % TBL_DEPTH);
  endfunction

  // Advance the shadow state by one command and return the frames it produces
  function automatic int dds_apply(input cmd_t c, output logic [WORD_W-1:0] wa,
                                   output logic [WORD_W-1:0] wb);
    wa = '0;
    wb = '0;
    case (c.op)
      OPC_TICK: begin
        if (mode != MODE_RUN) return 0;
        if (burst_left != 0) begin
          burst_left = burst_left - BURST_W'(1);
          if (burst_left == 0) mode = MODE_STOP;
        end
        acc_a = acc_a + step_a;
        acc_b = acc_b + step_b;
        wa = CMD_A | WORD_W'(tbl_a[tbl_addr(acc_a)]);
        wb = CMD_B | WORD_W'(tbl_b[tbl_addr(acc_b)]);
        return 2;
      end
      OPC_WRITE: begin
        if (c.chan == CHAN_A) begin
          tbl_a[c.idx] = c.code;
          wr_a[c.idx]  = 1'b1;
        end else begin
          tbl_b[c.idx] = c.code;
          wr_b[c.idx]  = 1'b1;
        end
      end
      OPC_RUN:   mode = MODE_RUN;
      OPC_STOP:  mode = MODE_STOP;
      OPC_BURST: burst_left = c.burst;
      OPC_DC: begin
        mode = MODE_DC;
        wa = ((c.chan == CHAN_A) ? CMD_A : CMD_B) | WORD_W'(c.code);
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic cmd_t pick_cmd();
    cmd_t c;
    int r;
    logic [IDX_W-1:0] na, nb;
    c.op    = OPC_TICK;
    c.chan  = 1'($urandom_range(0, 1));
    c.idx   = IDX_W'($urandom_range(0, TBL_DEPTH - 1));
    c.code  = CODE_W'($urandom_range(0, 4095));
    c.burst = BURST_W'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (mode != MODE_RUN && r < 55) c.op = OPC_RUN;
    else if (r < 62) c.op = OPC_WRITE;
    else if (r < 66) c.op = OPC_STOP;
    else if (r < 72) begin
      c.op = OPC_BURST;
      // mostly short bursts so expiry happens often
      if ($urandom_range(0, 3) != 0) c.burst = BURST_W'($urandom_range(1, 12));
      else if ($urandom_range(0, 1) == 0) c.burst = '0;
    end
    else if (r < 78) c.op = OPC_DC;
    else if (r < 80) c.op = ($urandom_range(0, 1) == 0) ? OPC_RSVD6 : OPC_RSVD7;
    else if (r < 83) c.op = OPC_RUN;
    // Never let a tick read a table entry that holds no code yet: load it first
    if (c.op == OPC_TICK && mode == MODE_RUN) begin
      na = tbl_addr(acc_a + step_a);
      nb = tbl_addr(acc_b + step_b);
      if (!wr_a[na]) begin
        c.op   = OPC_WRITE;
        c.chan = CHAN_A;
        c.idx  = na;
      end else if (!wr_b[nb]) begin
        c.op   = OPC_WRITE;
        c.chan = CHAN_B;
        c.idx  = nb;
      end
    end
    return c;
  endfunction

  task automatic push_frames(input int n, input logic [WORD_W-1:0] w0,
                             input logic [WORD_W-1:0] w1);
    if (n == 1) dac_frames_due.push_back('{w0, 1'b1});
    if (n == 2) begin
      dac_frames_due.push_back('{w0, 1'b0});
      dac_frames_due.push_back('{w1, 1'b1});
    end
  endtask

  task automatic add_row(input logic [OPC_W-1:0] op, input logic chan,
                         input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
                         input logic [BURST_W-1:0] burst, input bit typed, input int n,
                         input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
    cmd_row_t row;
    row.cmd   = '{op, chan, idx, code, burst};
    row.typed = typed;
    row.n     = n;
    row.w0    = w0;
    row.w1    = w1;
    dir_rows.push_back(row);
  endtask

  // Present one command and hold it until the block takes it
  task automatic drive_cmd(input cmd_t c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= c.op;
    in_ch.channel     <= c.chan;
    in_ch.table_index <= c.idx;
    in_ch.sample_code <= c.code;
    in_ch.burst_count <= c.burst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cmds_sent++;
    if (c.op == OPC_WRITE) tbl_writes++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (dac_frames_due.size() != 0);
  endtask

  task automatic cfg_set_steps(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_A;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_STEP_B;
    cfg_data  <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_a = a;
    step_b = b;
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Receiver: random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    frame_t f;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      frames_checked++;
      if (dac_frames_due.size() == 0) begin
        report_mismatch("frame with nothing pending", '0, out_ch.dac_word);
      end else begin
        f = dac_frames_due.pop_front();
        if (out_ch.dac_word !== f.word) report_mismatch("dac_word", f.word, out_ch.dac_word);
        if (out_ch.last !== f.last) report_mismatch("last", WORD_W'(f.last),
                                                   WORD_W'(out_ch.last));
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("[%0t] watchdog expired with %0d frames pending", $realtime,
                 dac_frames_due.size());
        $display("tb_dual_channel_dds_dac_feeder_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    int n, done;
    bit ign;
    logic [WORD_W-1:0] wa, wb;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.channel = 1'b0;
    in_ch.table_index = '0;
    in_ch.sample_code = '0;
    in_ch.burst_count = '0;
    run_ticks = 0;
    dc_frames = 0;
    tbl_writes = 0;
    cmds_sent = 0;
    src_idle_pct = 35;
    snk_idle_pct = 64;
    step_a = '0;
    step_b = '0;
    acc_a = '0;
    acc_b = '0;
    mode = MODE_STOP;
    burst_left = '0;
    foreach (wr_a[i]) begin
      wr_a[i] = 1'b0;
      wr_b[i] = 1'b0;
      tbl_a[i] = '0;
      tbl_b[i] = '0;
    end

    // A walks up one entry per tick, B walks down one entry per tick
    add_row(OPC_TICK,  CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 0, 16'h0000, 16'h0000);
    add_row(OPC_DC,    CHAN_A, 12'd0,    12'hFFF, 16'h0000, 1, 1, 16'h3FFF, 16'h0000);
    add_row(OPC_DC,    CHAN_B, 12'd4095, 12'h000, 16'h0000, 1, 1, 16'hB000, 16'h0000);
    add_row(OPC_WRITE, CHAN_A, 12'd1,    12'hFFF, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_WRITE, CHAN_B, 12'd4095, 12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_WRITE, CHAN_A, 12'd2,    12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_WRITE, CHAN_B, 12'd4094, 12'hFFF, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_WRITE, CHAN_A, 12'd3,    12'h5A5, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_WRITE, CHAN_B, 12'd4093, 12'hA5A, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_RUN,   CHAN_A, 12'd0,    12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_TICK,  CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 2, 16'h3FFF, 16'hB000);
    add_row(OPC_TICK,  CHAN_B, 12'd0,    12'h000, 16'h0000, 1, 2, 16'h3000, 16'hBFFF);
    add_row(OPC_STOP,  CHAN_A, 12'd0,    12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_TICK,  CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 0, 16'h0000, 16'h0000);
    add_row(OPC_BURST, CHAN_A, 12'd0,    12'h000, 16'h0001, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_RUN,   CHAN_A, 12'd0,    12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_TICK,  CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 2, 16'h35A5, 16'hBA5A);
    add_row(OPC_TICK,  CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 0, 16'h0000, 16'h0000);
    add_row(OPC_RSVD6, CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 0, 16'h0000, 16'h0000);
    add_row(OPC_RSVD7, CHAN_B, 12'd4095, 12'hFFF, 16'hFFFF, 1, 0, 16'h0000, 16'h0000);
    add_row(OPC_BURST, CHAN_A, 12'd0,    12'h000, 16'hFFFF, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_RUN,   CHAN_A, 12'd0,    12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);
    add_row(OPC_DC,    CHAN_A, 12'd0,    12'h123, 16'h0000, 1, 1, 16'h3123, 16'h0000);
    add_row(OPC_TICK,  CHAN_A, 12'd0,    12'h000, 16'h0000, 1, 0, 16'h0000, 16'h0000);
    add_row(OPC_STOP,  CHAN_A, 12'd0,    12'h000, 16'h0000, 0, 0, 16'h0000, 16'h0000);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_set_steps(32'h0010_0000, 32'hFFF0_0000);

    foreach (dir_rows[i]) begin
      drive_cmd(dir_rows[i].cmd);
      n = dds_apply(dir_rows[i].cmd, wa, wb);
      if (n == 2) run_ticks++;
      if (n == 1) dc_frames++;
      if (dir_rows[i].typed) push_frames(dir_rows[i].n, dir_rows[i].w0, dir_rows[i].w1);
      else push_frames(n, wa, wb);
    end

    for (int ph = 0; ph < 3; ph++) begin
      // Let the block settle before touching the step registers
      pause_until_drained();
      repeat (8) @(posedge clk);
      case (ph)
        0: begin
          src_idle_pct = 35;
          snk_idle_pct = 64;
          cfg_set_steps(32'h0000_0000, 32'hFFFF_FFFF);
        end
        1: begin
          src_idle_pct = 64;
          snk_idle_pct = 35;
          cfg_set_steps($urandom, $urandom);
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          cfg_set_steps(32'hFFFF_FFFF, 32'h0000_0000);
        end
      endcase
      done = 0;
      while (done < PHASE_CMDS) begin
        c = pick_cmd();
        ign = (c.op == OPC_TICK && mode != MODE_RUN) || (c.op > OPC_DC);
        drive_cmd(c);
        n = dds_apply(c, wa, wb);
        if (n == 2) run_ticks++;
        if (n == 1) dc_frames++;
        push_frames(n, wa, wb);
        if (!ign) begin
          done++;
          // Hold off the sender once per phase until the output side empties
          if (done == PHASE_CMDS / 2) pause_until_drained();
        end
      end
    end

    pause_until_drained();
    repeat (16) @(posedge clk);

    $display("sent %0d commands: %0d run ticks, %0d dc writes, %0d table writes",
             cmds_sent, run_ticks, dc_frames, tbl_writes);
    $display("checked %0d DAC frames over four step settings, %0d mismatches",
             frames_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_dual_channel_dds_dac_feeder_top: PASS");
    end else begin
      $display("tb_dual_channel_dds_dac_feeder_top: FAIL");
    end
    $finish;
  end

endmodule
